// ===== rtl/hgm_pkg.sv =====
package hgm_pkg;

    // Request to the shared iterative divide / square-root unit.
    typedef struct packed {
        logic go;
        logic sqrt_op;
    } t_iter_req;

    localparam int ITER_NUM_W = 64;
    localparam int ITER_DEN_W = 32;
    localparam int ITER_RES_W = 32;

endpackage

// ===== rtl/hgm_iter.sv =====
module hgm_iter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hgm_pkg::t_iter_req            i_req,
    input  logic [hgm_pkg::ITER_NUM_W-1:0] i_num,
    input  logic [hgm_pkg::ITER_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [hgm_pkg::ITER_RES_W-1:0] o_res
);
    import hgm_pkg::*;

    logic                  r_run;
    logic                  r_sqrt;
    logic                  r_done;
    logic [4:0]            r_k;
    logic [ITER_NUM_W-1:0] r_rem;
    logic [ITER_NUM_W-1:0] r_root;
    logic [ITER_DEN_W-1:0] r_den;
    logic [ITER_NUM_W-1:0] bitv;
    logic [ITER_NUM_W-1:0] trial;
    logic                  ge;

    // One compare and subtract per cycle serves both the restoring
    // square root (one root bit per step from two bits of the radicand) and the
    // restoring division (one quotient bit per step).
    always_comb begin
        bitv  = ITER_NUM_W'(1) << {r_k, 1'b0};
        trial = r_sqrt ? (r_root + bitv)
                       : ({{(ITER_NUM_W-ITER_DEN_W){1'b0}}, r_den} << r_k);
        ge    = (r_rem >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_sqrt <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_run  <= 1'b1;
                r_sqrt <= i_req.sqrt_op;
                r_k    <= i_req.sqrt_op ? 5'd31 : 5'd16;
            end else if (r_run) begin
                r_k <= r_k - 5'd1;
                if (r_k == 5'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem  <= i_num;
            r_root <= '0;
            r_den  <= i_den;
        end else if (r_run) begin
            if (ge) begin
                r_rem <= r_rem - trial;
            end
            if (r_sqrt) begin
                r_root <= ge ? ((r_root >> 1) + bitv) : (r_root >> 1);
            end else begin
                r_root <= {r_root[ITER_NUM_W-2:0], ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_root[ITER_RES_W-1:0];

endmodule

// ===== rtl/heightmap_grid_mesh_normals.sv =====
// Heightmap terrain mesh with per-vertex normals.
// Commands enter on start/i_mode/i_col/i_row/i_height; a command transfer
// happens at a clock edge with start high and busy low. Mode 0 writes one
// height sample into the internal store in that same cycle and leaves busy
// low. Mode 1 returns one vertex (position, texture coordinate, normal and
// index); mode 2 returns the six indices of one quad, one per cycle, with
// o_last on the sixth. Out-of-grid coordinates and mode 3 return nothing.
// Each result sits on the o_ ports for one cycle marked by o_valid; the
// receiver takes it in that cycle and cannot stall the block.
// For a vertex, each of up to six faces needs three store reads and one
// normalization, and every normalization of a nonzero vector runs a
// 32-step square root and three 17-step divisions on one shared
// divide/square-root unit; the two texture coordinates add two divisions.
// busy stays high throughout a vertex or quad command.
// Registers sit on an APB port at byte offsets 0, 4, 8 and 12. Reset
// returns the registers to their defaults and the sequencer to idle; the
// height store is not cleared and must be loaded before it is read.
module heightmap_grid_mesh_normals #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_row,
    input  logic signed [15:0] i_height,
    output logic               o_valid,
    output logic [23:0]        o_pos_x,
    output logic signed [24:0] o_pos_y,
    output logic [23:0]        o_pos_z,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [15:0]        o_vertex_index,
    output logic               o_last
);
    import hgm_pkg::*;

    localparam int AW = $clog2(MAX_COLS * MAX_ROWS);

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_VERTEX = 2'd1;
    localparam logic [1:0] MODE_QUAD   = 2'd2;

    localparam logic [1:0] REG_SCALE   = 2'd0;
    localparam logic [1:0] REG_SPACING = 2'd1;
    localparam logic [1:0] REG_WIDTH   = 2'd2;
    localparam logic [1:0] REG_DEPTH   = 2'd3;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_IDX    = 5'd1;
    localparam logic [4:0] S_IDX2   = 5'd2;
    localparam logic [4:0] S_FACE   = 5'd3;
    localparam logic [4:0] S_RD     = 5'd4;
    localparam logic [4:0] S_MH     = 5'd5;
    localparam logic [4:0] S_YS     = 5'd6;
    localparam logic [4:0] S_CX     = 5'd7;
    localparam logic [4:0] S_CY     = 5'd8;
    localparam logic [4:0] S_CZ     = 5'd9;
    localparam logic [4:0] S_UABS   = 5'd10;
    localparam logic [4:0] S_UNRM   = 5'd11;
    localparam logic [4:0] S_USQ    = 5'd12;
    localparam logic [4:0] S_UACC   = 5'd13;
    localparam logic [4:0] S_USQRT  = 5'd14;
    localparam logic [4:0] S_UDST   = 5'd15;
    localparam logic [4:0] S_UDIV   = 5'd16;
    localparam logic [4:0] S_UEND   = 5'd17;
    localparam logic [4:0] S_PX     = 5'd18;
    localparam logic [4:0] S_PZ     = 5'd19;
    localparam logic [4:0] S_TST    = 5'd20;
    localparam logic [4:0] S_TW     = 5'd21;
    localparam logic [4:0] S_VOUT   = 5'd22;
    localparam logic [4:0] S_QOUT   = 5'd23;

    // Configuration registers
    logic [15:0] r_scale;
    logic [15:0] r_spacing;
    logic [8:0]  r_width;
    logic [8:0]  r_depth;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= 16'd256;
            r_spacing <= 16'd256;
            r_width   <= 9'd256;
            r_depth   <= 9'd256;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SCALE:   r_scale   <= pwdata[15:0];
                REG_SPACING: r_spacing <= pwdata[15:0];
                REG_WIDTH:   r_width   <= pwdata[8:0];
                REG_DEPTH:   r_depth   <= pwdata[8:0];
                default:     r_scale   <= r_scale;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SCALE:   prdata = {16'd0, r_scale};
            REG_SPACING: prdata = {16'd0, r_spacing};
            REG_WIDTH:   prdata = {23'd0, r_width};
            REG_DEPTH:   prdata = {23'd0, r_depth};
            default:     prdata = '0;
        endcase
    end

    // Grid size in use, clamped to at least 2 and to the store.
    logic [8:0] w;
    logic [8:0] d;

    always_comb begin
        if (r_width < 9'd2) begin
            w = 9'd2;
        end else if (int'(r_width) > MAX_COLS) begin
            w = 9'(MAX_COLS);
        end else begin
            w = r_width;
        end
        if (r_depth < 9'd2) begin
            d = 9'd2;
        end else if (int'(r_depth) > MAX_ROWS) begin
            d = 9'(MAX_ROWS);
        end else begin
            d = r_depth;
        end
    end

    // Sequencer registers
    logic [4:0]         r_state;
    logic [3:0]         r_f;
    logic [1:0]         r_k;
    logic [2:0]         r_j;
    logic               r_center;
    logic               r_vert;
    logic [1:0]         r_mode;
    logic [7:0]         r_c;
    logic [7:0]         r_r;

    // Datapath registers
    logic signed [15:0] r_rdata;
    logic signed [63:0] r_prod;
    logic signed [24:0] r_y [3];
    logic signed [24:0] r_py;
    logic signed [47:0] r_vec [3];
    logic signed [47:0] r_acc [3];
    logic [46:0]        r_m [3];
    logic [2:0]         r_neg;
    logic [63:0]        r_s;
    logic [31:0]        r_l;
    logic signed [15:0] r_n [3];
    logic [23:0]        r_px;
    logic [23:0]        r_pz;
    logic [16:0]        r_tu;
    logic [15:0]        r_index;

    // Output registers
    logic               r_valid;
    logic [23:0]        r_o_px;
    logic signed [24:0] r_o_py;
    logic [23:0]        r_o_pz;
    logic [16:0]        r_o_tu;
    logic [16:0]        r_o_tv;
    logic signed [15:0] r_o_n [3];
    logic [15:0]        r_o_idx;
    logic               r_o_last;

    logic accept;
    logic vert_ok;
    logic quad_ok;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign vert_ok = ({1'b0, i_col} < w) && ({1'b0, i_row} < d);
    assign quad_ok = (({1'b0, i_col} + 9'd1) < w) && (({1'b0, i_row} + 9'd1) < d);

    // Face geometry. Face f covers quad (c-1+dx, r-1+dy); its low bit picks
    // the (TL,BL,TR) or (TR,BL,BR) triangle.
    logic       dx;
    logic       dy;
    logic       tri_b;
    logic       face_ok;
    logic       ox;
    logic       oy;
    logic [8:0] vc9;
    logic [8:0] vr9;
    logic [7:0] vc;
    logic [7:0] vr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    always_comb begin
        dx      = r_f[1];
        dy      = r_f[2];
        tri_b   = r_f[0];
        face_ok = (dx || (r_c != 8'd0)) && (dy || (r_r != 8'd0))
                  && (({1'b0, r_c} + 9'(dx)) < w) && (({1'b0, r_r} + 9'(dy)) < d)
                  && (tri_b ? !(dx && dy) : (dx || dy));
        ox      = (r_k == 2'd2) || (tri_b && (r_k == 2'd0));
        oy      = (r_k == 2'd1) || (tri_b && (r_k == 2'd2));
        vc9     = {1'b0, r_c} + 9'(dx) + 9'(ox) - 9'd1;
        vr9     = {1'b0, r_r} + 9'(dy) + 9'(oy) - 9'd1;
        if (r_center) begin
            vc = r_c;
            vr = r_r;
        end else begin
            vc = vc9[7:0];
            vr = vr9[7:0];
        end
        rd_addr = AW'(int'(vr) * MAX_COLS + int'(vc));
        wr_addr = AW'(int'(i_row) * MAX_COLS + int'(i_col));
        wr_en   = accept && (i_mode == MODE_LOAD)
                  && (int'(i_col) < MAX_COLS) && (int'(i_row) < MAX_ROWS);
    end

    // Height store
    logic [15:0] mem [MAX_COLS * MAX_ROWS];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_height;
        end
        r_rdata <= mem[rd_addr];
    end

    // Cross product terms: the x and z edge components are always a
    // multiple of the spacing, so only two height differences remain.
    logic signed [25:0] diff_x;
    logic signed [25:0] diff_z;

    always_comb begin
        if (tri_b) begin
            diff_x = 26'(r_y[1]) - 26'(r_y[2]);
            diff_z = 26'(r_y[0]) - 26'(r_y[2]);
        end else begin
            diff_x = 26'(r_y[0]) - 26'(r_y[2]);
            diff_z = 26'(r_y[0]) - 26'(r_y[1]);
        end
    end

    // Shared multiplier
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MH: begin
                mul_a = {{16{r_rdata[15]}}, r_rdata};
                mul_b = {16'd0, r_scale};
            end
            S_CX: begin
                mul_a = {16'd0, r_spacing};
                mul_b = {{6{diff_x[25]}}, diff_x};
            end
            S_CY: begin
                mul_a = {16'd0, r_spacing};
                mul_b = {16'd0, r_spacing};
            end
            S_CZ: begin
                mul_a = {16'd0, r_spacing};
                mul_b = {{6{diff_z[25]}}, diff_z};
            end
            S_USQ: begin
                mul_a = {2'd0, r_m[r_j[1:0]][29:0]};
                mul_b = {2'd0, r_m[r_j[1:0]][29:0]};
            end
            S_IDX: begin
                mul_a = {24'd0, r_r};
                mul_b = {23'd0, w};
            end
            S_PX: begin
                mul_a = {24'd0, r_c};
                mul_b = {16'd0, r_spacing};
            end
            S_PZ: begin
                mul_a = {24'd0, r_r};
                mul_b = {16'd0, r_spacing};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Normalization helpers
    logic        vec_zero;
    logic        any_hi8;
    logic        any_hi;
    logic        all_lo8;
    logic        all_lo;
    logic [63:0] s_sum;
    logic [32:0] y_round;

    always_comb begin
        vec_zero = (r_vec[0] == 48'sd0) && (r_vec[1] == 48'sd0) && (r_vec[2] == 48'sd0);
        any_hi8  = (|r_m[0][46:38]) || (|r_m[1][46:38]) || (|r_m[2][46:38]);
        any_hi   = (|r_m[0][46:30]) || (|r_m[1][46:30]) || (|r_m[2][46:30]);
        all_lo8  = !((|r_m[0][46:21]) || (|r_m[1][46:21]) || (|r_m[2][46:21]));
        all_lo   = !((|r_m[0][46:29]) || (|r_m[1][46:29]) || (|r_m[2][46:29]));
        s_sum    = r_s + 64'(r_prod);
        y_round  = r_prod[32:0] + 33'd128;
    end

    // Shared divide / square-root unit
    t_iter_req   iter_req;
    logic [63:0] iter_num;
    logic [31:0] iter_den;
    logic        iter_done;
    logic [31:0] iter_res;
    logic [8:0]  wm1;
    logic [8:0]  dm1;

    assign wm1 = w - 9'd1;
    assign dm1 = d - 9'd1;

    always_comb begin
        iter_req = '0;
        iter_num = '0;
        iter_den = '0;
        case (r_state)
            S_UACC: begin
                iter_req.go      = (r_j == 3'd2);
                iter_req.sqrt_op = 1'b1;
                iter_num         = s_sum;
            end
            S_UDST: begin
                iter_req.go = 1'b1;
                iter_num    = 64'({r_m[r_j[1:0]][29:0], 15'd0}) + 64'(r_l);
                iter_den    = {r_l[30:0], 1'b0};
            end
            S_TST: begin
                iter_req.go = 1'b1;
                if (r_j[0]) begin
                    iter_num = 64'({r_r, 16'd0}) + 64'(dm1 >> 1);
                    iter_den = 32'(dm1);
                end else begin
                    iter_num = 64'({r_c, 16'd0}) + 64'(wm1 >> 1);
                    iter_den = 32'(wm1);
                end
            end
            default: begin
                iter_req = '0;
            end
        endcase
    end

    hgm_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .i_num   (iter_num),
        .i_den   (iter_den),
        .o_done  (iter_done),
        .o_res   (iter_res)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_f      <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_center <= 1'b0;
            r_vert   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= (r_state == S_VOUT) || (r_state == S_QOUT);
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (((i_mode == MODE_VERTEX) && vert_ok)
                                   || ((i_mode == MODE_QUAD) && quad_ok))) begin
                        r_state <= S_IDX;
                    end
                end
                S_IDX: r_state <= S_IDX2;
                S_IDX2: begin
                    r_j      <= '0;
                    r_f      <= '0;
                    r_center <= 1'b0;
                    r_state  <= (r_mode == MODE_QUAD) ? S_QOUT : S_FACE;
                end
                S_FACE: begin
                    if (r_f[3]) begin
                        r_vert  <= 1'b1;
                        r_state <= S_UABS;
                    end else if (face_ok) begin
                        r_k     <= '0;
                        r_vert  <= 1'b0;
                        r_state <= S_RD;
                    end else begin
                        r_f <= r_f + 4'd1;
                    end
                end
                S_RD: r_state <= S_MH;
                S_MH: r_state <= S_YS;
                S_YS: begin
                    if (r_center) begin
                        r_state <= S_PX;
                    end else if (r_k == 2'd2) begin
                        r_state <= S_CX;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_RD;
                    end
                end
                S_CX: r_state <= S_CY;
                S_CY: r_state <= S_CZ;
                S_CZ: r_state <= S_UABS;
                S_UABS: r_state <= vec_zero ? S_UEND : S_UNRM;
                S_UNRM: begin
                    if (!any_hi && !all_lo) begin
                        r_j     <= '0;
                        r_state <= S_USQ;
                    end
                end
                S_USQ: r_state <= S_UACC;
                S_UACC: begin
                    if (r_j == 3'd2) begin
                        r_state <= S_USQRT;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_USQ;
                    end
                end
                S_USQRT: begin
                    if (iter_done) begin
                        r_j     <= '0;
                        r_state <= S_UDST;
                    end
                end
                S_UDST: r_state <= S_UDIV;
                S_UDIV: begin
                    if (iter_done) begin
                        if (r_j == 3'd2) begin
                            r_state <= S_UEND;
                        end else begin
                            r_j     <= r_j + 3'd1;
                            r_state <= S_UDST;
                        end
                    end
                end
                S_UEND: begin
                    if (r_vert) begin
                        r_center <= 1'b1;
                        r_state  <= S_RD;
                    end else begin
                        r_f     <= r_f + 4'd1;
                        r_state <= S_FACE;
                    end
                end
                S_PX: r_state <= S_PZ;
                S_PZ: begin
                    r_j     <= '0;
                    r_state <= S_TST;
                end
                S_TST: r_state <= S_TW;
                S_TW: begin
                    if (iter_done) begin
                        if (r_j[0]) begin
                            r_state <= S_VOUT;
                        end else begin
                            r_j     <= 3'd1;
                            r_state <= S_TST;
                        end
                    end
                end
                S_VOUT: r_state <= S_IDLE;
                S_QOUT: begin
                    r_j <= r_j + 3'd1;
                    if (r_j == 3'd5) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath
    logic [15:0] q_bl;
    logic [15:0] q_sel;

    always_comb begin
        q_bl = r_index + 16'(w);
        case (r_j)
            3'd0:    q_sel = r_index;
            3'd1:    q_sel = q_bl;
            3'd2:    q_sel = r_index + 16'd1;
            3'd3:    q_sel = r_index + 16'd1;
            3'd4:    q_sel = q_bl;
            default: q_sel = q_bl + 16'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mode <= i_mode;
                r_c    <= i_col;
                r_r    <= i_row;
            end
            S_IDX: r_prod <= mul_p;
            S_IDX2: begin
                r_index <= r_prod[15:0] + 16'(r_c);
                for (int i = 0; i < 3; i++) begin
                    r_acc[i] <= '0;
                end
            end
            S_FACE: begin
                if (r_f[3]) begin
                    for (int i = 0; i < 3; i++) begin
                        r_vec[i] <= r_acc[i];
                    end
                end
            end
            S_MH: r_prod <= mul_p;
            S_YS: begin
                if (r_center) begin
                    r_py <= y_round[32:8];
                end else begin
                    r_y[r_k] <= y_round[32:8];
                end
            end
            S_CX: r_vec[0] <= mul_p[47:0];
            S_CY: r_vec[1] <= mul_p[47:0];
            S_CZ: r_vec[2] <= mul_p[47:0];
            S_UABS: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_vec[i][47];
                    r_m[i]   <= r_vec[i][47] ? 47'(-r_vec[i]) : r_vec[i][46:0];
                    r_n[i]   <= '0;
                end
            end
            S_UNRM: begin
                // Scale all magnitudes together until the largest lies in
                // [2^29, 2^30); coarse steps of eight bits when far away.
                r_s <= '0;
                for (int i = 0; i < 3; i++) begin
                    if (any_hi8) begin
                        r_m[i] <= r_m[i] >> 8;
                    end else if (any_hi) begin
                        r_m[i] <= r_m[i] >> 1;
                    end else if (all_lo8) begin
                        r_m[i] <= r_m[i] << 8;
                    end else if (all_lo) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
            end
            S_USQ: r_prod <= mul_p;
            S_UACC: r_s <= s_sum;
            S_USQRT: begin
                if (iter_done) begin
                    r_l <= iter_res;
                end
            end
            S_UDIV: begin
                if (iter_done) begin
                    r_n[r_j[1:0]] <= r_neg[r_j[1:0]] ? -iter_res[15:0] : iter_res[15:0];
                end
            end
            S_UEND: begin
                if (!r_vert) begin
                    for (int i = 0; i < 3; i++) begin
                        r_acc[i] <= r_acc[i] + 48'(r_n[i]);
                    end
                end
            end
            S_PX: r_px <= mul_p[23:0];
            S_PZ: r_pz <= mul_p[23:0];
            S_TW: begin
                if (iter_done && !r_j[0]) begin
                    r_tu <= iter_res[16:0];
                end
            end
            default: begin
                r_l <= r_l;
            end
        endcase
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_VOUT) begin
            r_o_px   <= r_px;
            r_o_py   <= r_py;
            r_o_pz   <= r_pz;
            r_o_tu   <= r_tu;
            r_o_tv   <= iter_res[16:0];
            for (int i = 0; i < 3; i++) begin
                r_o_n[i] <= r_n[i];
            end
            r_o_idx  <= r_index;
            r_o_last <= 1'b1;
        end else if (r_state == S_QOUT) begin
            r_o_px   <= '0;
            r_o_py   <= '0;
            r_o_pz   <= '0;
            r_o_tu   <= '0;
            r_o_tv   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_o_n[i] <= '0;
            end
            r_o_idx  <= q_sel;
            r_o_last <= (r_j == 3'd5);
        end
    end

    // The second texture division finishes in S_TW; hold its quotient
    // until the result registers load in S_VOUT.
    assign o_valid        = r_valid;
    assign o_pos_x        = r_o_px;
    assign o_pos_y        = r_o_py;
    assign o_pos_z        = r_o_pz;
    assign o_tex_u        = r_o_tu;
    assign o_tex_v        = r_o_tv;
    assign o_norm_x       = r_o_n[0];
    assign o_norm_y       = r_o_n[1];
    assign o_norm_z       = r_o_n[2];
    assign o_vertex_index = r_o_idx;
    assign o_last         = r_o_last;

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !$past(busy)) |-> $past(start))
        else $error("busy rose without a command transfer");

    a_valid_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final result outside a command");

    a_iter_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_done |-> (r_state == S_USQRT || r_state == S_UDIV || r_state == S_TW))
        else $error("divide unit finished while not awaited");

endmodule
